>>> src/matrix_multiply_engine_top_macros.svh
// Assertion macros used by the engine's top module.
`ifndef MATRIX_MULTIPLY_ENGINE_TOP_MACROS_SVH
`define MATRIX_MULTIPLY_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define MME_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define MME_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/mme_pkg.sv
package mme_pkg;

	// Fixed field widths of the request, result and configuration words.
	localparam int IDX_W     = 4;
	localparam int IN_ELEM_W = 16;
	localparam int RES_W     = 32;
	localparam int DIM_W     = 5;
	localparam int CFG_IDX_W = 2;

	// Defaults for the top-level parameters.
	localparam int MAX_DIM_DEF    = 16;
	localparam int ELEM_WIDTH_DEF = 16;

	// Reset value of every dimension register.
	localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_LEFT_ROWS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_COLS = 2'd2;

	// Request kinds; the fourth code carries no meaning and is dropped.
	typedef enum logic [1:0] {
		REQ_LOAD_LEFT  = 2'd0,
		REQ_LOAD_RIGHT = 2'd1,
		REQ_QUERY      = 2'd2
	} req_kind_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} mme_state_t;

	// Control from the sequencer to the multiply-accumulate unit.
	typedef struct packed {
		logic clear;
		logic issue;
	} mac_ctrl_t;

	// Status from the multiply-accumulate unit.
	typedef struct packed {
		logic busy;
	} mac_stat_t;

endpackage

>>> src/mme_if.sv
// Request channel: loads and queries.
interface mme_req_if import mme_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic [1:0]                  req_type;
	logic [IDX_W-1:0]            row_index;
	logic [IDX_W-1:0]            col_index;
	logic signed [IN_ELEM_W-1:0] elem_value;

	modport source (output valid, req_type, row_index, col_index, elem_value, input ready);
	modport sink   (input valid, req_type, row_index, col_index, elem_value, output ready);
endinterface

// Result channel: one word for each query.
interface mme_res_if import mme_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [RES_W-1:0] product_value;
	logic                    in_range;

	modport source (output valid, product_value, in_range, input ready);
	modport sink   (input valid, product_value, in_range, output ready);
endinterface

>>> src/mme_ram.sv
module mme_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> src/mme_mac.sv
module mme_mac import mme_pkg::*; #(
	parameter int MAX_DIM    = MAX_DIM_DEF,
	parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mac_ctrl_t                    ctrl,
	input  logic signed [ELEM_WIDTH-1:0] a,
	input  logic signed [ELEM_WIDTH-1:0] b,
	output mac_stat_t                    stat,
	output logic signed [RES_W-1:0]      sum
);

	localparam int PROD_W = 2 * ELEM_WIDTH;
	localparam int GROW_W = PROD_W + $clog2(MAX_DIM) + 1;
	localparam int ACC_W  = GROW_W > RES_W + 1 ? GROW_W : RES_W + 1;

	localparam logic signed [RES_W:0] SAT_HI33 = 33'sh0_7FFF_FFFF;
	localparam logic signed [RES_W:0] SAT_LO33 = 33'sh1_8000_0000;
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(SAT_HI33);
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(SAT_LO33);

	logic                     v_s1;
	logic                     v_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;

	// Valid flags follow the store read latency and then the multiplier register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ctrl.issue;
			v_s2 <= v_s1;
		end
	end

	// Shared multiplier followed by the accumulator.
	always_ff @(posedge clk) begin
		if (v_s1) begin
			prod_s2 <= a * b;
		end
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	assign stat.busy = v_s1 | v_s2;

	// Clamp the running sum to the signed 32-bit range.
	always_comb begin
		if (acc_q > SAT_HI) begin
			sum = SAT_HI33[RES_W-1:0];
		end else if (acc_q < SAT_LO) begin
			sum = SAT_LO33[RES_W-1:0];
		end else begin
			sum = acc_q[RES_W-1:0];
		end
	end

endmodule

>>> src/matrix_multiply_engine_top.sv
// Matrix multiply engine. The block holds a left and a right matrix of signed Q8.8 words
// and answers queries for one element of their product in signed Q16.16, saturated to
// 32 bits. A load word writes one element; loads outside the configured size are
// dropped. A query in range is worked through to its result before the next word is
// accepted, since one multiply-accumulate unit walks the inner index, one product per
// cycle, fed by the single read port of each store. A query out of range returns zero
// with in_range low. Loads are accepted while an earlier result still waits on the
// result channel. The dimension registers must only be written while the engine is
// idle; element values are undefined until loaded.
module matrix_multiply_engine_top import mme_pkg::*; #(
	parameter int MAX_DIM    = MAX_DIM_DEF,
	parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_wdata,
	mme_req_if.sink              req,
	mme_res_if.source            res
);

`include "matrix_multiply_engine_top_macros.svh"

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;

	mme_state_t state_q, state_d;

	logic [DIM_W-1:0] left_rows_q, inner_size_q, right_cols_q;
	logic [DIM_W-1:0] nr, nk, nc;
	logic [DIM_W-1:0] req_row, req_col;
	logic [IDX_W-1:0] row_q, col_q;
	logic [DIM_W-1:0] k_q;
	logic             ok_q;
	logic             accept, is_query, query_ok, k_last;
	logic             left_we, right_we;
	logic [ADDR_W-1:0] waddr, left_raddr, right_raddr;
	logic [ELEM_WIDTH-1:0] store_data;
	logic [ELEM_WIDTH-1:0] left_rdata, right_rdata;
	mac_ctrl_t        mac_ctrl;
	mac_stat_t        mac_stat;
	logic signed [RES_W-1:0] mac_sum;
	logic             out_load;
	logic             res_valid_q;
	logic signed [RES_W-1:0] product_q;
	logic             in_range_q;

	// Dimension registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_rows_q  <= DIM_RESET;
			inner_size_q <= DIM_RESET;
			right_cols_q <= DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LEFT_ROWS:  left_rows_q  <= cfg_wdata;
				CFG_INNER_SIZE: inner_size_q <= cfg_wdata;
				CFG_RIGHT_COLS: right_cols_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Dimensions above the store size act as the store size.
	assign nr = 32'(left_rows_q) > MAX_DIM ? DIM_W'(MAX_DIM) : left_rows_q;
	assign nk = 32'(inner_size_q) > MAX_DIM ? DIM_W'(MAX_DIM) : inner_size_q;
	assign nc = 32'(right_cols_q) > MAX_DIM ? DIM_W'(MAX_DIM) : right_cols_q;

	// Decode of the incoming word.
	assign accept   = req.valid && req.ready;
	assign req_row  = DIM_W'(req.row_index);
	assign req_col  = DIM_W'(req.col_index);
	assign is_query = (req.req_type == REQ_QUERY);
	assign query_ok = (req_row < nr) && (req_col < nc);
	assign left_we  = accept && (req.req_type == REQ_LOAD_LEFT) && (req_row < nr) && (req_col < nk);
	assign right_we = accept && (req.req_type == REQ_LOAD_RIGHT) && (req_row < nk) &&
		(req_col < nc);
	assign waddr    = ADDR_W'(int'(req.row_index) * MAX_DIM + int'(req.col_index));

	// Fit the loaded value into the store width.
	generate
		if (ELEM_WIDTH >= IN_ELEM_W) begin : g_wide
			assign store_data = ELEM_WIDTH'(req.elem_value);
		end else begin : g_narrow
			localparam logic signed [IN_ELEM_W-1:0] FIT_HI =
				IN_ELEM_W'((1 << (ELEM_WIDTH - 1)) - 1);
			localparam logic signed [IN_ELEM_W-1:0] FIT_LO = -FIT_HI - 16'sd1;
			always_comb begin
				if (req.elem_value > FIT_HI) begin
					store_data = ELEM_WIDTH'(FIT_HI);
				end else if (req.elem_value < FIT_LO) begin
					store_data = ELEM_WIDTH'(FIT_LO);
				end else begin
					store_data = ELEM_WIDTH'(req.elem_value);
				end
			end
		end
	endgenerate

	// Read addresses walk the left row and the right column.
	assign left_raddr  = ADDR_W'(int'(row_q) * MAX_DIM + int'(k_q));
	assign right_raddr = ADDR_W'(int'(k_q) * MAX_DIM + int'(col_q));
	assign k_last      = (k_q == DIM_W'(nk - 5'd1));

	mme_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_left_ram (
		.clk   (clk),
		.we    (left_we),
		.waddr (waddr),
		.wdata (store_data),
		.raddr (left_raddr),
		.rdata (left_rdata)
	);

	mme_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_right_ram (
		.clk   (clk),
		.we    (right_we),
		.waddr (waddr),
		.wdata (store_data),
		.raddr (right_raddr),
		.rdata (right_rdata)
	);

	mme_mac #(.MAX_DIM(MAX_DIM), .ELEM_WIDTH(ELEM_WIDTH)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.a      (left_rdata),
		.b      (right_rdata),
		.stat   (mac_stat),
		.sum    (mac_sum)
	);

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && is_query) begin
					state_d = (query_ok && (nk != '0)) ? ST_RUN : ST_FINISH;
				end
			end
			ST_RUN: begin
				if (k_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!mac_stat.busy) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!res_valid_q || res.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer. Ready is always high in idle, so a valid query
	// there is an accepted one.
	always_comb begin
		req.ready      = 1'b0;
		mac_ctrl.clear = 1'b0;
		mac_ctrl.issue = 1'b0;
		out_load       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready      = 1'b1;
				mac_ctrl.clear = req.valid && is_query;
			end
			ST_RUN:    mac_ctrl.issue = 1'b1;
			ST_DRAIN:  ;
			ST_FINISH: out_load = !res_valid_q || res.ready;
			default:   ;
		endcase
	end

	// Sequencer state and inner-index counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				k_q <= '0;
			end else if (state_q == ST_RUN) begin
				k_q <= k_q + 5'd1;
			end
		end
	end

	// Indices of the query under way.
	always_ff @(posedge clk) begin
		if (accept && is_query) begin
			row_q <= req.row_index;
			col_q <= req.col_index;
			ok_q  <= query_ok;
		end
	end

	// Output register for the result word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			product_q  <= ok_q ? mac_sum : '0;
			in_range_q <= ok_q;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.product_value = product_q;
	assign res.in_range      = in_range_q;

	`MME_ASSERT_NEXT(a_oor_finish, clk, arst_n, accept && is_query && !query_ok,
		state_q == ST_FINISH, "out-of-range query did not go straight to finish")
	`MME_ASSERT_NOW(a_k_bound, clk, arst_n, state_q == ST_RUN, k_q < nk,
		"inner index ran past the inner size")
	`MME_ASSERT_NOW(a_finish_idle_mac, clk, arst_n, state_q == ST_FINISH, !mac_stat.busy,
		"result taken while products still in flight")
	`MME_ASSERT_NOW(a_rise_from_finish, clk, arst_n, $rose(res_valid_q),
		$past(state_q == ST_FINISH), "result word appeared outside finish")
	`MME_ASSERT_NOW(a_oor_zero, clk, arst_n, res_valid_q && !in_range_q, product_q == '0,
		"out-of-range result is not zero")

endmodule
